// ===== src/ansi_sgr_color_stream_parser_defines.svh =====
// Assertion macros shared by the color stream parser modules.
`ifndef ANSI_SGR_COLOR_STREAM_PARSER_DEFINES_SVH
`define ANSI_SGR_COLOR_STREAM_PARSER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ASCP_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define ASCP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ascp_pkg.sv =====
// Types, constants and the parameter-apply function of the color stream parser.
package ascp_pkg;

    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_STYLE = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // Escape parser states.
    localparam logic [2:0] PS_TEXT     = 3'd0;
    localparam logic [2:0] PS_ESC      = 3'd1;
    localparam logic [2:0] PS_CSI      = 3'd2;
    localparam logic [2:0] PS_PARAM    = 3'd3;
    localparam logic [2:0] PS_BRACKET  = 3'd4;
    localparam logic [2:0] PS_PRIV     = 3'd5;
    localparam logic [2:0] PS_PRIV_ARG = 3'd6;

    localparam logic [7:0] CHAR_CAN  = 8'h18;
    localparam logic [7:0] CHAR_SUB  = 8'h1A;
    localparam logic [7:0] CHAR_ESC  = 8'h1B;
    localparam logic [7:0] CHAR_CSI  = 8'h9B;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_BEL  = 8'h07;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_DEL  = 8'h7F;
    localparam logic [7:0] CHAR_SGR  = 8'h6D; // 'm'
    localparam logic [7:0] CHAR_LBR  = 8'h5B; // '['
    localparam logic [7:0] CHAR_SEMI = 8'h3B; // ';'
    localparam logic [7:0] CHAR_QUES = 8'h3F; // '?'
    localparam logic [7:0] CHAR_EQ   = 8'h3D; // '='
    localparam logic [7:0] CHAR_GT   = 8'h3E; // '>'
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_J    = 8'h4A;
    localparam logic [7:0] CHAR_K    = 8'h4B;
    localparam logic [7:0] CHAR_D0   = 8'h30; // '0'
    localparam logic [7:0] CHAR_D9   = 8'h39; // '9'

    localparam logic [9:0] FG_DEFAULT = 10'd7;
    localparam logic [9:0] BG_DEFAULT = 10'd0;
    localparam logic [9:0] COLOR_MAX  = 10'd1023;

    localparam logic signed [11:0] PARAM_BOLD = 12'sd1;
    localparam logic signed [11:0] PARAM_FG   = 12'sd30;
    localparam logic signed [11:0] PARAM_BG   = 12'sd40;
    localparam logic signed [11:0] ACC_FLOOR  = -12'sd128;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       close_prev;
        logic       open_span;
        logic       show_fg;
        logic [9:0] fg;
        logic       show_bg;
        logic [9:0] bg;
        logic       last;
    } t_record;

    // Colors of the sequence in progress and the parameter accumulator.
    // The accumulator is kept clamped to -128..1023, the only range a digit sees.
    typedef struct packed {
        logic [9:0]         fg;
        logic [9:0]         bg;
        logic signed [10:0] acc;
    } t_seq;

    function automatic t_seq apply_param(logic signed [11:0] x, logic [9:0] fg,
                                         logic [9:0] bg);
        t_seq              r;
        logic [10:0]       fg_sum;
        logic signed [11:0] off;
        fg_sum = {1'b0, fg} + 11'd8;
        r.fg   = fg;
        r.bg   = bg;
        if (x == 12'sd0) begin
            r.fg = FG_DEFAULT;
            r.bg = BG_DEFAULT;
        end else if (x == PARAM_BOLD) begin
            r.fg = (fg_sum > {1'b0, COLOR_MAX}) ? COLOR_MAX : fg_sum[9:0];
        end else if (x >= PARAM_BG) begin
            off  = x - PARAM_BG;
            r.bg = off[9:0];
        end else if (x >= PARAM_FG) begin
            off  = x - PARAM_FG;
            r.fg = ((fg >= 10'd8) ? 10'd8 : 10'd0) + {6'd0, off[3:0]};
        end
        r.acc = (x < ACC_FLOOR) ? ACC_FLOOR[10:0] : x[10:0];
        return r;
    endfunction

endpackage

// ===== src/ascp_parser.sv =====
// Escape sequence parser and color state; turns one byte into up to two records.
`include "ansi_sgr_color_stream_parser_defines.svh"

module ascp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_eot,
    output logic [1:0]       o_push_cnt,
    output ascp_pkg::t_record o_rec0,
    output ascp_pkg::t_record o_rec1
);

    logic [2:0]         r_ps, n_ps;
    logic [9:0]         r_cur_fg, n_cur_fg, r_cur_bg, n_cur_bg;
    logic [9:0]         r_seq_fg, n_seq_fg, r_seq_bg, n_seq_bg;
    logic signed [10:0] r_acc, n_acc;
    logic               r_style_pending, n_style_pending;
    logic               r_span_open, n_span_open;

    logic [9:0]         eff_fg, eff_bg;
    logic signed [10:0] eff_acc;
    logic signed [15:0] acc_ext, acc_mul;
    logic signed [11:0] x_digit, x_priv;
    ascp_pkg::t_seq     p_digit, p_priv;
    ascp_pkg::t_record  char_rec, style_rec, close_rec;
    logic               sty_fg, sty_bg;

    // Entering the parameter state from CSI starts from a reset parameter.
    assign eff_fg  = (r_ps == ascp_pkg::PS_CSI) ? ascp_pkg::FG_DEFAULT : r_seq_fg;
    assign eff_bg  = (r_ps == ascp_pkg::PS_CSI) ? ascp_pkg::BG_DEFAULT : r_seq_bg;
    assign eff_acc = (r_ps == ascp_pkg::PS_CSI) ? 11'sd0 : r_acc;

    // acc * 10 + digit, saturated at the top only.
    assign acc_ext = {{5{eff_acc[10]}}, eff_acc};
    assign acc_mul = (acc_ext <<< 3) + (acc_ext <<< 1) + $signed({12'd0, i_byte[3:0]});
    assign x_digit = (acc_mul > 16'sd1023) ? 12'sd1023 : acc_mul[11:0];
    assign x_priv  = {{4{i_byte[7]}}, i_byte};

    assign p_digit = ascp_pkg::apply_param(x_digit, r_cur_fg, r_cur_bg);
    assign p_priv  = ascp_pkg::apply_param(x_priv, r_cur_fg, r_cur_bg);

    assign sty_fg = (r_seq_fg != ascp_pkg::FG_DEFAULT);
    assign sty_bg = (r_seq_bg != ascp_pkg::BG_DEFAULT);

    always_comb begin
        char_rec      = '0;
        char_rec.kind = ascp_pkg::KIND_CHAR;
        char_rec.ch   = i_byte;
        char_rec.last = 1'b1;

        style_rec            = '0;
        style_rec.kind       = ascp_pkg::KIND_STYLE;
        style_rec.close_prev = r_span_open;
        style_rec.open_span  = sty_fg | sty_bg;
        style_rec.show_fg    = sty_fg;
        style_rec.fg         = sty_fg ? r_seq_fg : 10'd0;
        style_rec.show_bg    = sty_bg;
        style_rec.bg         = sty_bg ? r_seq_bg : 10'd0;

        close_rec            = '0;
        close_rec.kind       = ascp_pkg::KIND_CLOSE;
        close_rec.close_prev = 1'b1;
        close_rec.last       = 1'b1;
    end

    always_comb begin
        n_ps            = r_ps;
        n_cur_fg        = r_cur_fg;
        n_cur_bg        = r_cur_bg;
        n_seq_fg        = r_seq_fg;
        n_seq_bg        = r_seq_bg;
        n_acc           = r_acc;
        n_style_pending = r_style_pending;
        n_span_open     = r_span_open;
        o_push_cnt      = 2'd0;
        o_rec0          = '0;
        o_rec1          = '0;

        if (i_accept) begin
            if (i_eot) begin
                if (r_span_open) begin
                    o_push_cnt = 2'd1;
                    o_rec0     = close_rec;
                end
                n_ps            = ascp_pkg::PS_TEXT;
                n_cur_fg        = ascp_pkg::FG_DEFAULT;
                n_cur_bg        = ascp_pkg::BG_DEFAULT;
                n_seq_fg        = ascp_pkg::FG_DEFAULT;
                n_seq_bg        = ascp_pkg::BG_DEFAULT;
                n_acc           = 11'sd0;
                n_style_pending = 1'b0;
                n_span_open     = 1'b0;
            end else if (i_byte == ascp_pkg::CHAR_CAN || i_byte == ascp_pkg::CHAR_SUB) begin
                n_ps = ascp_pkg::PS_TEXT;
            end else if (i_byte == ascp_pkg::CHAR_ESC) begin
                n_ps = ascp_pkg::PS_ESC;
            end else if (i_byte == ascp_pkg::CHAR_CSI) begin
                n_ps = ascp_pkg::PS_CSI;
            end else if (i_byte inside {ascp_pkg::CHAR_BEL, ascp_pkg::CHAR_NUL,
                                        ascp_pkg::CHAR_DEL, ascp_pkg::CHAR_VT,
                                        ascp_pkg::CHAR_CR, ascp_pkg::CHAR_FF}) begin
                n_ps = r_ps;
            end else begin
                case (r_ps)
                    ascp_pkg::PS_TEXT: begin
                        if (r_style_pending) begin
                            o_push_cnt      = 2'd2;
                            o_rec0          = style_rec;
                            o_rec1          = char_rec;
                            n_span_open     = sty_fg | sty_bg;
                            n_style_pending = 1'b0;
                        end else begin
                            o_push_cnt = 2'd1;
                            o_rec0     = char_rec;
                        end
                    end
                    ascp_pkg::PS_ESC: begin
                        if (i_byte == ascp_pkg::CHAR_LBR) begin
                            n_ps = ascp_pkg::PS_CSI;
                        end else if (i_byte inside {ascp_pkg::CHAR_EQ, ascp_pkg::CHAR_GT,
                                                    ascp_pkg::CHAR_H}) begin
                            n_ps = ascp_pkg::PS_TEXT;
                        end
                    end
                    ascp_pkg::PS_CSI, ascp_pkg::PS_PARAM: begin
                        if (r_ps == ascp_pkg::PS_CSI && (i_byte inside {ascp_pkg::CHAR_K,
                                ascp_pkg::CHAR_H, ascp_pkg::CHAR_J})) begin
                            n_ps = ascp_pkg::PS_TEXT;
                        end else if (r_ps == ascp_pkg::PS_CSI &&
                                     i_byte == ascp_pkg::CHAR_QUES) begin
                            n_ps = ascp_pkg::PS_PRIV;
                        end else begin
                            n_ps     = ascp_pkg::PS_PARAM;
                            n_seq_fg = eff_fg;
                            n_seq_bg = eff_bg;
                            n_acc    = eff_acc;
                            if (i_byte == ascp_pkg::CHAR_SGR) begin
                                if (r_cur_fg != eff_fg || r_cur_bg != eff_bg) begin
                                    n_cur_fg        = eff_fg;
                                    n_cur_bg        = eff_bg;
                                    n_acc           = 11'sd0;
                                    n_style_pending = 1'b1;
                                end
                                n_ps = ascp_pkg::PS_TEXT;
                            end else if (i_byte == ascp_pkg::CHAR_LBR) begin
                                n_ps = ascp_pkg::PS_BRACKET;
                            end else if (i_byte == ascp_pkg::CHAR_SEMI) begin
                                n_seq_fg = ascp_pkg::FG_DEFAULT;
                                n_seq_bg = ascp_pkg::BG_DEFAULT;
                                n_acc    = 11'sd0;
                            end else if (i_byte inside {[ascp_pkg::CHAR_D0:ascp_pkg::CHAR_D9]})
                            begin
                                n_seq_fg = p_digit.fg;
                                n_seq_bg = p_digit.bg;
                                n_acc    = p_digit.acc;
                            end else begin
                                n_ps = ascp_pkg::PS_TEXT;
                            end
                        end
                    end
                    ascp_pkg::PS_PRIV: begin
                        n_seq_fg = p_priv.fg;
                        n_seq_bg = p_priv.bg;
                        n_acc    = p_priv.acc;
                        n_ps     = ascp_pkg::PS_PRIV_ARG;
                    end
                    ascp_pkg::PS_BRACKET, ascp_pkg::PS_PRIV_ARG: begin
                        n_ps = ascp_pkg::PS_TEXT;
                    end
                    default: begin
                        n_ps = r_ps;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps            <= ascp_pkg::PS_TEXT;
            r_cur_fg        <= ascp_pkg::FG_DEFAULT;
            r_cur_bg        <= ascp_pkg::BG_DEFAULT;
            r_seq_fg        <= ascp_pkg::FG_DEFAULT;
            r_seq_bg        <= ascp_pkg::BG_DEFAULT;
            r_acc           <= 11'sd0;
            r_style_pending <= 1'b0;
            r_span_open     <= 1'b0;
        end else begin
            r_ps            <= n_ps;
            r_cur_fg        <= n_cur_fg;
            r_cur_bg        <= n_cur_bg;
            r_seq_fg        <= n_seq_fg;
            r_seq_bg        <= n_seq_bg;
            r_acc           <= n_acc;
            r_style_pending <= n_style_pending;
            r_span_open     <= n_span_open;
        end
    end

    `ASCP_ASSERT_NEXT(a_style_consumed, o_push_cnt == 2'd2, !r_style_pending, "pending style kept")
    `ASCP_ASSERT_NEXT(a_eot_resets, i_accept && i_eot, r_ps == ascp_pkg::PS_TEXT && !r_span_open && !r_style_pending, "end of text did not reset")
    `ASCP_ASSERT_NEXT(a_span_idle, !i_accept, $stable(r_span_open) && $stable(r_ps), "state moved without a transfer")

endmodule

// ===== src/ascp_rec_fifo.sv =====
// Output record queue: up to two in a cycle, one out a cycle while i_ready.
`include "ansi_sgr_color_stream_parser_defines.svh"

module ascp_rec_fifo #(
    parameter int DEPTH = ascp_pkg::OUT_FIFO_DEPTH // power of two, at least 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  ascp_pkg::t_record i_rec0,
    input  ascp_pkg::t_record i_rec1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ascp_pkg::t_record o_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ascp_pkg::t_record r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign pop     = o_valid & i_ready;
    // Room for the worst case of two records from the next byte.
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    `ASCP_ASSERT_NOW(a_count_bound, r_count <= CNT_W'(DEPTH), "record queue count beyond depth")
    `ASCP_ASSERT_IMPL(a_no_overflow, i_push_cnt != 2'd0, ({1'b0, r_count} + (CNT_W+1)'(i_push_cnt)) <= (CNT_W+1)'(DEPTH), "record queue overflow")

endmodule

// ===== src/ansi_sgr_color_stream_parser.sv =====
// Top level of the terminal color escape parser with streaming ports.
//
// Input channel: one byte of terminal text per transfer on i_s_axis_tdata;
// i_s_axis_tlast set marks end of text, the byte is then ignored, an open
// span is closed and all parser and color state returns to reset.
// Output channel: one record per transfer. o_m_axis_tuser holds the record
// kind (character, style change, final close), o_m_axis_tdata the fields,
// and o_m_axis_tlast marks the last record caused by one input byte.
// Latency: records of a byte accepted at one edge are offered from the next
// cycle on. Throughput: one byte per cycle while o_s_axis_tready is high;
// a byte that carries a pending style change yields two records.
// The records sit in a small queue (FIFO_DEPTH entries); o_s_axis_tready
// is high while the queue has room for two records, so a stalled receiver
// stops input only once the queue holds more than FIFO_DEPTH-2 records.
// Reset (synchronous, active low) empties the queue and puts the parser in
// plain text with foreground 7, background 0 and no open span.
module ansi_sgr_color_stream_parser #(
    parameter int FIFO_DEPTH = ascp_pkg::OUT_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] text_byte
    input  logic        i_s_axis_tlast,  // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] char_out, [8] close_previous, [9] open_span, [10] show_fg,
    // [20:11] fg_color, [21] show_bg, [31:22] bg_color
    output logic [31:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,  // [1:0] record_kind
    output logic        o_m_axis_tlast   // last
);

    logic              accept;
    logic              room;
    logic [1:0]        push_cnt;
    ascp_pkg::t_record rec0, rec1, head;

    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid & room;

    ascp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_s_axis_tdata),
        .i_eot      (i_s_axis_tlast),
        .o_push_cnt (push_cnt),
        .o_rec0     (rec0),
        .o_rec1     (rec1)
    );

    ascp_rec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rec_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_rec0     (rec0),
        .i_rec1     (rec1),
        .o_room     (room),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_rec      (head)
    );

    assign o_m_axis_tdata = {head.bg, head.show_bg, head.fg, head.show_fg,
                             head.open_span, head.close_prev, head.ch};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the terminal color escape parser with streaming ports.
`timescale 1ns / 1ps

// Tracks the parser and color state of the block and the records it still owes.
class sgr_scoreboard;
    logic [2:0]        state;
    logic [9:0]        cur_fg, cur_bg, seq_fg, seq_bg;
    int                acc;
    bit                style_pend, span_open;
    ascp_pkg::t_record owed_q[$];
    int                n_bad;

    function new();
        n_bad = 0;
        clear();
    endfunction

    function void clear();
        state      = ascp_pkg::PS_TEXT;
        cur_fg     = ascp_pkg::FG_DEFAULT;
        cur_bg     = ascp_pkg::BG_DEFAULT;
        seq_fg     = ascp_pkg::FG_DEFAULT;
        seq_bg     = ascp_pkg::BG_DEFAULT;
        acc        = 0;
        style_pend = 1'b0;
        span_open  = 1'b0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    function void owe(logic [1:0] kind, logic [7:0] ch, logic cls, logic opn, logic sf,
                      logic [9:0] fg, logic sbg, logic [9:0] bg, logic lst);
        ascp_pkg::t_record r;
        r.kind       = kind;
        r.ch         = ch;
        r.close_prev = cls;
        r.open_span  = opn;
        r.show_fg    = sf;
        r.fg         = fg;
        r.show_bg    = sbg;
        r.bg         = bg;
        r.last       = lst;
        owed_q.push_back(r);
    endfunction

    // Applies one parameter to the committed colors; only the last one survives.
    function void set_param(int x);
        logic [9:0] fg, bg;
        int         t;
        fg = cur_fg;
        bg = cur_bg;
        if (x == 0) begin
            fg = ascp_pkg::FG_DEFAULT;
            bg = ascp_pkg::BG_DEFAULT;
        end else if (x == 1) begin
            t  = int'(cur_fg) + 8;
            fg = (t > 1023) ? 10'd1023 : t[9:0];
        end else if (x >= 40) begin
            t  = x - 40;
            bg = (t > 1023) ? 10'd1023 : t[9:0];
        end else if (x >= 30) begin
            t  = ((cur_fg >= 10'd8) ? 8 : 0) + x - 30;
            fg = t[9:0];
        end
        seq_fg = fg;
        seq_bg = bg;
        acc    = x;
    endfunction

    function void param_byte(logic [7:0] b);
        int a, v;
        if (b == ascp_pkg::CHAR_SGR) begin
            if (cur_bg != seq_bg || cur_fg != seq_fg) begin
                cur_fg     = seq_fg;
                cur_bg     = seq_bg;
                acc        = 0;
                style_pend = 1'b1;
            end
            state = ascp_pkg::PS_TEXT;
        end else if (b == ascp_pkg::CHAR_LBR) begin
            state = ascp_pkg::PS_BRACKET;
        end else if (b == ascp_pkg::CHAR_SEMI) begin
            set_param(0);
        end else if (b >= ascp_pkg::CHAR_D0 && b <= ascp_pkg::CHAR_D9) begin
            a = acc;
            if (a > 1023) a = 1023;
            if (a < -128) a = -128;
            v = a * 10 + (int'(b) - int'(ascp_pkg::CHAR_D0));
            set_param((v > 1023) ? 1023 : v);
        end else begin
            state = ascp_pkg::PS_TEXT;
        end
    endfunction

    // Called for every accepted input transfer.
    function void note_input(logic [7:0] b, logic eot);
        int  sch;
        bit  fa, fb, op;
        sch = (b >= 8'h80) ? int'(b) - 256 : int'(b);
        if (eot) begin
            if (span_open) owe(ascp_pkg::KIND_CLOSE, 8'd0, 1'b1, 1'b0, 1'b0, 10'd0,
                               1'b0, 10'd0, 1'b1);
            clear();
            return;
        end
        case (b)
            ascp_pkg::CHAR_CAN, ascp_pkg::CHAR_SUB: begin
                state = ascp_pkg::PS_TEXT;
                return;
            end
            ascp_pkg::CHAR_ESC: begin
                state = ascp_pkg::PS_ESC;
                return;
            end
            ascp_pkg::CHAR_CSI: begin
                state = ascp_pkg::PS_CSI;
                return;
            end
            ascp_pkg::CHAR_BEL, ascp_pkg::CHAR_NUL, ascp_pkg::CHAR_DEL,
            ascp_pkg::CHAR_VT, ascp_pkg::CHAR_CR, ascp_pkg::CHAR_FF: return;
            default: ;
        endcase
        case (state)
            ascp_pkg::PS_TEXT: begin
                if (style_pend) begin
                    fa = (seq_fg != ascp_pkg::FG_DEFAULT);
                    fb = (seq_bg != ascp_pkg::BG_DEFAULT);
                    op = fa || fb;
                    owe(ascp_pkg::KIND_STYLE, 8'd0, span_open, op, fa, fa ? seq_fg : 10'd0,
                        fb, fb ? seq_bg : 10'd0, 1'b0);
                    span_open  = op;
                    style_pend = 1'b0;
                end
                owe(ascp_pkg::KIND_CHAR, b, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 10'd0, 1'b1);
            end
            ascp_pkg::PS_ESC: begin
                if (b == ascp_pkg::CHAR_LBR) begin
                    state = ascp_pkg::PS_CSI;
                end else if (b == ascp_pkg::CHAR_EQ || b == ascp_pkg::CHAR_GT ||
                             b == ascp_pkg::CHAR_H) begin
                    state = ascp_pkg::PS_TEXT;
                end
            end
            ascp_pkg::PS_CSI: begin
                if (b == ascp_pkg::CHAR_K || b == ascp_pkg::CHAR_H || b == ascp_pkg::CHAR_J) begin
                    state = ascp_pkg::PS_TEXT;
                end else if (b == ascp_pkg::CHAR_QUES) begin
                    state = ascp_pkg::PS_PRIV;
                end else begin
                    // The byte that opens the parameter list is itself a parameter byte.
                    set_param(0);
                    state = ascp_pkg::PS_PARAM;
                    param_byte(b);
                end
            end
            ascp_pkg::PS_PARAM: param_byte(b);
            ascp_pkg::PS_PRIV: begin
                set_param(sch);
                state = ascp_pkg::PS_PRIV_ARG;
            end
            ascp_pkg::PS_BRACKET, ascp_pkg::PS_PRIV_ARG: state = ascp_pkg::PS_TEXT;
            default: ;
        endcase
    endfunction

    function string fmt(ascp_pkg::t_record r);
        return $sformatf("kind=%0d ch=%02h cls=%0b open=%0b sf=%0b fg=%0d sb=%0b bg=%0d last=%0b",
                         r.kind, r.ch, r.close_prev, r.open_span, r.show_fg, r.fg,
                         r.show_bg, r.bg, r.last);
    endfunction

    // Called for every accepted output transfer.
    function void check(logic [1:0] kind, logic [31:0] data, logic lst);
        ascp_pkg::t_record got, want;
        got.kind       = kind;
        got.ch         = data[7:0];
        got.close_prev = data[8];
        got.open_span  = data[9];
        got.show_fg    = data[10];
        got.fg         = data[20:11];
        got.show_bg    = data[21];
        got.bg         = data[31:22];
        got.last       = lst;
        if (owed_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected record: %s", fmt(got));
            return;
        end
        want = owed_q.pop_front();
        if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) $display("record mismatch: expected %s, actual %s",
                                      fmt(want), fmt(got));
        end
    endfunction
endclass

module tb_top;
    localparam int ITEM_TARGET  = 2000;
    localparam int CALM_TAIL    = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] text_byte
    logic        i_s_axis_tlast;   // end_of_text
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] char_out, [8] close_previous, [9] open_span, [10] show_fg,
    // [20:11] fg_color, [21] show_bg, [31:22] bg_color
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;   // [1:0] record_kind
    logic        o_m_axis_tlast;

    sgr_scoreboard sb;
    int            n_sent;
    int            cycles;
    int            tx_pct;
    bit            idle_en;

    ansi_sgr_color_stream_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    // Receiver: ready drops in bursts whose frequency changes now and then.
    initial begin
        int rx_pct;
        rx_pct          = 20;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_pct = 0;
                    1: rx_pct = 10;
                    2: rx_pct = 30;
                    default: rx_pct = 60;
                endcase
            end
            if (idle_en && $urandom_range(0, 99) < rx_pct) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // One input transfer, with an optional gap in front of it.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (idle_en && $urandom_range(0, 99) < tx_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(b, eot);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_intro();
        if ($urandom_range(0, 1)) begin
            send_byte(ascp_pkg::CHAR_CSI, 1'b0);
        end else begin
            send_byte(ascp_pkg::CHAR_ESC, 1'b0);
            send_byte(ascp_pkg::CHAR_LBR, 1'b0);
        end
    endtask

    task automatic send_printable();
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(8'hA0, 8'hFF)), 1'b0);
        else send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
    endtask

    task automatic send_number(input int val);
        int dg[10];
        int n;
        n = 0;
        do begin
            dg[n] = val % 10;
            val   = val / 10;
            n++;
        end while (val > 0);
        if ($urandom_range(0, 7) == 0) send_byte(ascp_pkg::CHAR_D0, 1'b0);
        for (int i = n - 1; i >= 0; i--) begin
            send_byte(8'(int'(ascp_pkg::CHAR_D0) + dg[i]), 1'b0);
        end
    endtask

    function automatic int pick_param();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return $urandom_range(30, 39);
            3: return $urandom_range(40, 49);
            4: return $urandom_range(2, 29);
            5: return $urandom_range(50, 1023);
            6: return $urandom_range(1024, 99999);
            default: return $urandom_range(0, 9);
        endcase
    endfunction

    // Back-to-back bold sequences drive the foreground up to saturation.
    task automatic send_bold_streak(input int reps);
        for (int i = 0; i < reps; i++) begin
            send_intro();
            send_byte(ascp_pkg::CHAR_D0 + 8'd1, 1'b0);
            send_byte(ascp_pkg::CHAR_SGR, 1'b0);
            if (i % 16 == 15) send_printable();
        end
        send_printable();
    endtask

    task automatic random_segment();
        int n;
        int pick;
        case ($urandom_range(0, 3))
            0: tx_pct = 0;
            1: tx_pct = 5;
            2: tx_pct = 20;
            default: tx_pct = 50;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_intro();
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (i > 0) send_byte(ascp_pkg::CHAR_SEMI, 1'b0);
                if ($urandom_range(0, 9) != 0) send_number(pick_param());
            end
            case ($urandom_range(0, 19))
                0: begin
                    send_byte(ascp_pkg::CHAR_LBR, 1'b0);
                    send_byte(8'($urandom), 1'b0);
                end
                1: send_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
                2: send_byte(ascp_pkg::CHAR_ESC, 1'b0);
                default: send_byte(ascp_pkg::CHAR_SGR, 1'b0);
            endcase
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) send_printable();
        end else if (pick < 55) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) send_printable();
        end else if (pick < 63) begin
            // Private sequence: the byte after the question mark acts as a parameter.
            send_intro();
            send_byte(ascp_pkg::CHAR_QUES, 1'b0);
            send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b0);
            send_printable();
        end else if (pick < 70) begin
            case ($urandom_range(0, 5))
                0: begin
                    send_byte(ascp_pkg::CHAR_ESC, 1'b0);
                    send_byte(ascp_pkg::CHAR_EQ, 1'b0);
                end
                1: begin
                    send_byte(ascp_pkg::CHAR_ESC, 1'b0);
                    send_byte(ascp_pkg::CHAR_GT, 1'b0);
                end
                2: begin
                    send_byte(ascp_pkg::CHAR_ESC, 1'b0);
                    send_byte(ascp_pkg::CHAR_H, 1'b0);
                end
                3: begin
                    send_byte(ascp_pkg::CHAR_ESC, 1'b0);
                    send_byte(8'($urandom), 1'b0);
                end
                4: begin
                    send_intro();
                    case ($urandom_range(0, 2))
                        0: send_byte(ascp_pkg::CHAR_K, 1'b0);
                        1: send_byte(ascp_pkg::CHAR_H, 1'b0);
                        default: send_byte(ascp_pkg::CHAR_J, 1'b0);
                    endcase
                end
                default: begin
                    send_intro();
                    send_byte(ascp_pkg::CHAR_LBR, 1'b0);
                    send_byte(8'($urandom), 1'b0);
                end
            endcase
            send_printable();
        end else if (pick < 85) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
        end else if (pick < 89) begin
            send_byte(8'($urandom), 1'b1);
        end else if (pick < 90) begin
            send_bold_streak($urandom_range(20, 140));
        end else begin
            // Sequence cut short by a cancel or a new escape.
            send_intro();
            send_number(pick_param());
            case ($urandom_range(0, 2))
                0: send_byte(ascp_pkg::CHAR_CAN, 1'b0);
                1: send_byte(ascp_pkg::CHAR_SUB, 1'b0);
                default: send_byte(ascp_pkg::CHAR_ESC, 1'b0);
            endcase
            send_printable();
        end
    endtask

    initial begin
        sb              = new();
        n_sent          = 0;
        cycles          = 0;
        tx_pct          = 30;
        idle_en         = 1'b1;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme bytes, a dropped control byte and a saturating parameter.
        send_byte(ascp_pkg::CHAR_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(ascp_pkg::CHAR_CSI, 1'b0);
        send_text("9999mx");
        // Bold followed by a foreground: only the last parameter counts.
        send_byte(ascp_pkg::CHAR_ESC, 1'b0);
        send_text("[1;32m");
        // Private sequence changes the sequence colors while a style is pending.
        send_byte(ascp_pkg::CHAR_ESC, 1'b0);
        send_text("[?5qy");
        send_byte(ascp_pkg::CHAR_CSI, 1'b0);
        send_text("K");
        send_byte(ascp_pkg::CHAR_ESC, 1'b0);
        send_text("=");
        send_byte(ascp_pkg::CHAR_SUB, 1'b0);
        send_byte(ascp_pkg::CHAR_DEL, 1'b0);
        // End of text with a span open, then again with none open.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        send_bold_streak(130);
        while (n_sent < ITEM_TARGET) begin
            if (n_sent >= ITEM_TARGET - CALM_TAIL) idle_en = 1'b0;
            random_segment();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_bad == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/ascp_pkg.sv
src/ascp_parser.sv
src/ascp_rec_fifo.sv
src/ansi_sgr_color_stream_parser.sv
tb/tb_top.sv
